[sv/max_priority_queue_assert.svh]
// assertion macros for the max priority queue
`ifndef MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define MPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MPQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/mpq_pkg.sv]
// shared constants, types and controller/datapath structs for the priority queue
`default_nettype none
package mpq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_PUSH = 2'd0;
  localparam cmd_t CMD_POP  = 2'd1;
  localparam cmd_t CMD_PEEK = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TAIL,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic do_push;
    logic scan_rd;
    logic rd_last;
    logic move_wr;
    logic finish;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[sv/mpq_in_if.sv]
// request channel interface of the priority queue
`default_nettype none
interface mpq_in_if;
  logic                               valid;
  logic                               ready;
  logic [mpq_pkg::CMD_W-1:0]          command;
  logic signed [mpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

[sv/mpq_out_if.sv]
// result channel interface of the priority queue
`default_nettype none
interface mpq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mpq_pkg::VALUE_W-1:0] result_value;
  logic [mpq_pkg::STAT_W-1:0]         status;
  logic [mpq_pkg::COUNT_W-1:0]        count;
  logic                               is_empty;

  modport source (output valid, output result_value, output status, output count,
                  output is_empty, input ready);
  modport sink (input valid, input result_value, input status, input count,
                input is_empty, output ready);
endinterface
`default_nettype wire

[sv/max_priority_queue.sv]
// top level of the max priority queue: controller plus datapath
// one request at a time; the next request is taken once the previous result is registered
// push, no-op and error requests go from the execute state straight to the done state
// peek and pop scan with one memory read per stored entry; pop then moves the last entry
// synchronous active-low reset empties the queue and drops any pending result
`default_nettype none
module max_priority_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  mpq_in_if.sink    in_ch,
  mpq_out_if.source out_ch
);

  mpq_pkg::dp_ctrl_t ctrl;
  mpq_pkg::dp_stat_t stat;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mpq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_command (in_ch.command),
    .in_value   (in_ch.value),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

[sv/mpq_ctrl.sv]
// controller state machine sequencing push, scan and pop moves
`default_nettype none
module mpq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mpq_pkg::dp_stat_t stat,
  output mpq_pkg::dp_ctrl_t      ctrl
);

  mpq_pkg::state_t state_r;
  mpq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    case (state_r)
      mpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = mpq_pkg::S_EXEC;
        end
      end
      mpq_pkg::S_EXEC: begin
        state_nxt = mpq_pkg::S_DONE;
        if (stat.cmd == mpq_pkg::CMD_PUSH) begin
          ctrl.do_push = !stat.full;
        end else if (stat.cmd == mpq_pkg::CMD_POP || stat.cmd == mpq_pkg::CMD_PEEK) begin
          if (!stat.empty) begin
            state_nxt = mpq_pkg::S_SCAN;
          end
        end
      end
      mpq_pkg::S_SCAN: begin
        ctrl.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = mpq_pkg::S_TAIL;
        end
      end
      mpq_pkg::S_TAIL: begin
        if (stat.cmd == mpq_pkg::CMD_POP) begin
          ctrl.rd_last = 1'b1;
          state_nxt    = mpq_pkg::S_MOVE;
        end else begin
          state_nxt = mpq_pkg::S_DONE;
        end
      end
      mpq_pkg::S_MOVE: begin
        ctrl.move_wr = 1'b1;
        state_nxt    = mpq_pkg::S_DONE;
      end
      mpq_pkg::S_DONE: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = mpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/mpq_datapath.sv]
// entry memory, count, max scan and result register of the priority queue
`default_nettype none
`include "max_priority_queue_assert.svh"
module mpq_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mpq_pkg::dp_ctrl_t                  ctrl,
  output mpq_pkg::dp_stat_t                       stat,
  input  wire logic [mpq_pkg::CMD_W-1:0]          in_command,
  input  wire logic signed [mpq_pkg::VALUE_W-1:0] in_value,
  mpq_out_if.source                               out_ch
);

  logic signed [mpq_pkg::VALUE_W-1:0] mem_r [mpq_pkg::CAPACITY];

  mpq_pkg::cmd_t                      cmd_r;
  logic signed [mpq_pkg::VALUE_W-1:0] value_r;
  logic [mpq_pkg::CNT_W-1:0]          count_r;
  logic signed [mpq_pkg::VALUE_W-1:0] rdata_r;
  logic [mpq_pkg::IDX_W-1:0]          rd_idx_r;
  logic                               rd_en_d_r;
  logic [mpq_pkg::IDX_W-1:0]          rd_idx_d_r;
  logic signed [mpq_pkg::VALUE_W-1:0] best_val_r;
  logic [mpq_pkg::IDX_W-1:0]          best_idx_r;

  // error flags captured when the command is checked against the count
  logic                               push_fail_r;
  logic                               empty_fail_r;

  logic                               out_valid_r;
  logic signed [mpq_pkg::VALUE_W-1:0] out_value_r;
  mpq_pkg::status_t                   out_status_r;
  logic [mpq_pkg::COUNT_W-1:0]        out_count_r;
  logic                               out_empty_r;

  logic [mpq_pkg::IDX_W-1:0]          last_idx;
  logic [mpq_pkg::IDX_W-1:0]          rd_addr;
  logic                               rd_en;
  logic                               wr_en;
  logic [mpq_pkg::IDX_W-1:0]          wr_addr;
  logic signed [mpq_pkg::VALUE_W-1:0] wr_data;
  logic                               is_max_cmd;
  logic                               is_empty;
  logic                               is_full;
  mpq_pkg::status_t                   res_status;
  logic signed [mpq_pkg::VALUE_W-1:0] res_value;

  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
  assign last_idx   = mpq_pkg::IDX_W'(count_r - mpq_pkg::CNT_W'(1));
  assign rd_en      = ctrl.scan_rd | ctrl.rd_last;
  assign rd_addr    = ctrl.rd_last ? last_idx : rd_idx_r;
  assign wr_en      = ctrl.do_push | ctrl.move_wr;
  assign wr_addr    = ctrl.do_push ? mpq_pkg::IDX_W'(count_r) : best_idx_r;
  assign wr_data    = ctrl.do_push ? value_r : rdata_r;
  assign is_max_cmd = (cmd_r == mpq_pkg::CMD_POP) || (cmd_r == mpq_pkg::CMD_PEEK);

  always_comb begin
    res_status = mpq_pkg::ST_OK;
    res_value  = '0;
    if (push_fail_r) begin
      res_status = mpq_pkg::ST_FULL;
    end else if (empty_fail_r) begin
      res_status = mpq_pkg::ST_EMPTY;
    end else if (is_max_cmd) begin
      res_value = best_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      push_fail_r  <= (in_command == mpq_pkg::CMD_PUSH) && is_full;
      empty_fail_r <= ((in_command == mpq_pkg::CMD_POP) || (in_command == mpq_pkg::CMD_PEEK))
                      && is_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_command;
      value_r <= in_value;
    end
    rd_idx_d_r <= rd_idx_r;
    if (rd_en_d_r && (rd_idx_d_r == '0 || rdata_r > best_val_r)) begin
      best_val_r <= rdata_r;
      best_idx_r <= rd_idx_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      rd_en_d_r <= 1'b0;
    end else begin
      rd_en_d_r <= ctrl.scan_rd;
      if (ctrl.load) begin
        rd_idx_r <= '0;
      end else if (ctrl.scan_rd) begin
        rd_idx_r <= rd_idx_r + mpq_pkg::IDX_W'(1);
      end
      if (ctrl.do_push) begin
        count_r <= count_r + mpq_pkg::CNT_W'(1);
      end else if (ctrl.move_wr) begin
        count_r <= count_r - mpq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= mpq_pkg::COUNT_W'(count_r);
      out_empty_r  <= is_empty;
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.empty     = is_empty;
    stat.full      = is_full;
    stat.scan_last = (mpq_pkg::CNT_W'(rd_idx_r) == count_r - mpq_pkg::CNT_W'(1));
    stat.out_free  = !out_valid_r || out_ch.ready;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.count        = out_count_r;
  assign out_ch.is_empty     = out_empty_r;

  `MPQ_ASSERT_ALWAYS(a_count_bound, count_r <= mpq_pkg::CNT_W'(mpq_pkg::CAPACITY), "count overrun")
  `MPQ_ASSERT_IMPLY(a_push_room, ctrl.do_push, !is_full, "push into full store")
  `MPQ_ASSERT_IMPLY(a_move_nonempty, ctrl.move_wr, !is_empty, "move with empty store")
  `MPQ_ASSERT_IMPLY(a_finish_free, ctrl.finish, !out_valid_r || out_ch.ready, "result overwritten")

endmodule
`default_nettype wire

[bench/max_priority_queue_test.sv]
// self-checking testbench for the max priority queue: directed and random push, pop, peek and no-op traffic
`timescale 1ns / 1ps
module max_priority_queue_test;

  localparam mpq_pkg::cmd_t CMD_NOP = 2'd3;
  localparam int IDLE_PCT = 22;
  localparam int REQ_IDX_W = 10;
  localparam int MAX_REQUESTS = 1 << REQ_IDX_W;

  typedef struct {
    mpq_pkg::cmd_t                      command;
    logic signed [mpq_pkg::VALUE_W-1:0] value;
  } queue_request_t;

  typedef struct {
    logic signed [mpq_pkg::VALUE_W-1:0] result_value;
    mpq_pkg::status_t                   status;
    logic [mpq_pkg::COUNT_W-1:0]        count;
    logic                               is_empty;
  } queue_response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               req_valid = 1'b0;
  mpq_pkg::cmd_t                      req_command = mpq_pkg::CMD_PUSH;
  logic signed [mpq_pkg::VALUE_W-1:0] req_value = '0;
  logic                               resp_ready = 1'b0;

  mpq_in_if  in_ch ();
  mpq_out_if out_ch ();

  assign in_ch.valid   = req_valid;
  assign in_ch.command = req_command;
  assign in_ch.value   = req_value;
  assign out_ch.ready  = resp_ready;

  max_priority_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  queue_request_t  pending_requests [MAX_REQUESTS];
  int              pending_wr = 0;
  int              pending_rd = 0;
  queue_response_t expected_responses [MAX_REQUESTS];
  int              expected_wr = 0;
  int              expected_rd = 0;
  queue_request_t  current_request;
  int              accepted_count = 0;
  int              error_count = 0;

  // shadow copy of the queue contents
  logic signed [mpq_pkg::VALUE_W-1:0] shadow_entries [mpq_pkg::CAPACITY];
  int                                 shadow_count = 0;

  // no idling while this stretch of requests goes through
  wire quiet = (accepted_count >= 300) && (accepted_count < 480);

  function automatic queue_response_t compute_queue_response(queue_request_t req);
    queue_response_t resp;
    int best;
    int last;
    resp.result_value = '0;
    resp.status = mpq_pkg::ST_OK;
    case (req.command)
      mpq_pkg::CMD_PUSH: begin
        if (shadow_count >= mpq_pkg::CAPACITY) begin
          resp.status = mpq_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_count[mpq_pkg::IDX_W-1:0]] = req.value;
          shadow_count++;
        end
      end
      mpq_pkg::CMD_POP, mpq_pkg::CMD_PEEK: begin
        if (shadow_count == 0) begin
          resp.status = mpq_pkg::ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_entries[i[mpq_pkg::IDX_W-1:0]] >
                shadow_entries[best[mpq_pkg::IDX_W-1:0]]) best = i;
          end
          resp.result_value = shadow_entries[best[mpq_pkg::IDX_W-1:0]];
          if (req.command == mpq_pkg::CMD_POP) begin
            last = shadow_count - 1;
            shadow_entries[best[mpq_pkg::IDX_W-1:0]] = shadow_entries[last[mpq_pkg::IDX_W-1:0]];
            shadow_count--;
          end
        end
      end
      default: begin
      end
    endcase
    resp.count = shadow_count[mpq_pkg::COUNT_W-1:0];
    resp.is_empty = (shadow_count == 0);
    return resp;
  endfunction

  function automatic void add_request(mpq_pkg::cmd_t command,
                                      logic signed [mpq_pkg::VALUE_W-1:0] value);
    queue_request_t req;
    req.command = command;
    req.value = value;
    pending_requests[pending_wr[REQ_IDX_W-1:0]] = req;
    pending_wr++;
  endfunction

  task automatic check_field(string name, logic signed [mpq_pkg::VALUE_W-1:0] want,
                             logic signed [mpq_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    bit go;
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && in_ch.ready) begin
        expected_responses[expected_wr[REQ_IDX_W-1:0]] = compute_queue_response(current_request);
        expected_wr++;
        accepted_count++;
      end
      if (!req_valid || in_ch.ready) begin
        go = quiet || ($urandom_range(99) >= IDLE_PCT);
        if (go && pending_rd < pending_wr) begin
          current_request = pending_requests[pending_rd[REQ_IDX_W-1:0]];
          pending_rd++;
          req_valid <= 1'b1;
          req_command <= current_request.command;
          req_value <= current_request.value;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    queue_response_t want;
    if (!rst_n) begin
      resp_ready <= 1'b0;
    end else begin
      if (out_ch.valid && resp_ready) begin
        if (expected_rd == expected_wr) begin
          $display("%0t: unexpected result, expected none, actual value %0d status %0d count %0d",
                   $time, out_ch.result_value, out_ch.status, out_ch.count);
          error_count++;
        end else begin
          want = expected_responses[expected_rd[REQ_IDX_W-1:0]];
          expected_rd++;
          check_field("result_value", want.result_value, out_ch.result_value);
          check_field("status", mpq_pkg::VALUE_W'(want.status),
                      mpq_pkg::VALUE_W'(out_ch.status));
          check_field("count", mpq_pkg::VALUE_W'(want.count), mpq_pkg::VALUE_W'(out_ch.count));
          check_field("is_empty", mpq_pkg::VALUE_W'(want.is_empty),
                      mpq_pkg::VALUE_W'(out_ch.is_empty));
        end
      end
      resp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int push_pct;
    int phase_left;
    int roll;
    mpq_pkg::cmd_t cmd;
    logic signed [mpq_pkg::VALUE_W-1:0] val;

    // empty queue, extremes, equal maxima, fill to full
    add_request(mpq_pkg::CMD_POP, 32'sd5);
    add_request(mpq_pkg::CMD_PEEK, -32'sd5);
    add_request(CMD_NOP, 32'h7fffffff);
    add_request(mpq_pkg::CMD_PUSH, 32'h7fffffff);
    add_request(mpq_pkg::CMD_PUSH, 32'h80000000);
    add_request(mpq_pkg::CMD_PUSH, -32'sd1);
    add_request(mpq_pkg::CMD_PUSH, 32'h7fffffff);
    add_request(mpq_pkg::CMD_PEEK, '0);
    add_request(mpq_pkg::CMD_POP, '0);
    add_request(CMD_NOP, 32'h80000000);
    for (int i = 0; i < 13; i++) begin
      add_request(mpq_pkg::CMD_PUSH, (i % 3 == 0) ? '0 : i - 6);
    end
    add_request(mpq_pkg::CMD_PUSH, 32'h12345678);
    add_request(mpq_pkg::CMD_PEEK, -32'sd1);

    phase_left = 0;
    push_pct = 50;
    for (int n = 0; n < 800; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 15);
        case ($urandom_range(2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      roll = $urandom_range(99);
      if (roll < 3) cmd = CMD_NOP;
      else if (roll < 3 + push_pct * 97 / 100) cmd = mpq_pkg::CMD_PUSH;
      else if ($urandom_range(99) < 70) cmd = mpq_pkg::CMD_POP;
      else cmd = mpq_pkg::CMD_PEEK;
      case ($urandom_range(9))
        0, 1, 2: val = $urandom_range(7) - 4;
        3: val = 32'h7fffffff;
        4: val = 32'h80000000;
        default: val = $urandom;
      endcase
      add_request(cmd, val);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_rd < pending_wr || req_valid || expected_rd < expected_wr) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_rd == expected_wr) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/mpq_pkg.sv
sv/mpq_in_if.sv
sv/mpq_out_if.sv
sv/mpq_ctrl.sv
sv/mpq_datapath.sv
sv/max_priority_queue.sv
bench/max_priority_queue_test.sv
